/* hdl/aligned_block_allocator_defines.svh */
// Assertion macros for the aligned block allocator.
// Included by the top level; no other dependencies.
`ifndef ALIGNED_BLOCK_ALLOCATOR_DEFINES_SVH
`define ALIGNED_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define ABA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ABA_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ABA_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ABA_ASSERT(label, clk, rst, prop, msg)
`define ABA_IMPLIES(label, clk, rst, ante, cons, msg)
`define ABA_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* hdl/aba_pkg.sv */
// Shared types, field widths and status codes of the aligned block allocator.
// No dependencies.
package aba_pkg;

   localparam int HANDLE_W = 4;
   localparam int COUNT_W  = 7;
   localparam int MSIZE_W  = 7;
   localparam int STATUS_W = 2;
   localparam int START_W  = 6;
   localparam int MAP_W    = 64;
   // span arithmetic: candidate plus rounded size stays below 256
   localparam int SPAN_W   = 8;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_USED    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ABSENT  = 2'd3;

   // half-open block range [lo, hi) handed to the span unit
   typedef struct packed {
      logic [SPAN_W-1:0] lo;
      logic [SPAN_W-1:0] hi;
   } span_req_type;

   // smallest power of two not below n
   function automatic logic [SPAN_W-1:0] round_pow2(input logic [COUNT_W-1:0] n);
      logic [SPAN_W-1:0] p;
      logic [SPAN_W-1:0] trial;
      p = '0;
      for (int k = SPAN_W - 1; k >= 0; k--) begin
         trial = SPAN_W'(1) << k;
         if (trial >= SPAN_W'(n)) begin
            p = trial;
         end
      end
      return p;
   endfunction

endpackage

/* hdl/aba_span_unit.sv */
// Range mask unit: sets every block bit inside a half-open range.
// Depends on aba_pkg for the range request type.
module aba_span_unit #(
   parameter int BLOCKS = 64
) (
   input  aba_pkg::span_req_type req,
   output logic [BLOCKS-1:0]     mask
);

   always_comb begin
      for (int b = 0; b < BLOCKS; b++) begin
         mask[b] = (aba_pkg::SPAN_W'(b) >= req.lo) && (aba_pkg::SPAN_W'(b) < req.hi);
      end
   end

endmodule

/* hdl/aligned_block_allocator.sv */
// Aligned block allocator: one request at a time, one result per request.
// A release or an early reject passes through decode and finish; a reserve also walks
// aligned candidate starts in scan and commits the first fit, if any, before finish.
// A new request is taken only in idle, after the last result is registered; a held response delays the next result.
// Reset: synchronous, active high; all blocks free, no handles live, memory size 64.
// Depends on aba_pkg, aba_span_unit and aligned_block_allocator_defines.svh.
`include "aligned_block_allocator_defines.svh"

module aligned_block_allocator #(
   parameter int MEM_BLOCKS = 64,
   parameter int HANDLES    = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request: tuser = action
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,
   // request tdata: handle[3:0], block_count[10:4], zero[15:11]
   input  logic [15:0] req_tdata,
   // response tdata: status[1:0], start_index[7:2], free_map[71:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [aba_pkg::MSIZE_W-1:0] csr_wdata
);

   localparam int SPAN_W      = aba_pkg::SPAN_W;
   localparam int IDX_W       = $clog2(MEM_BLOCKS);
   localparam int SIZE_W      = $clog2(MEM_BLOCKS + 1);
   localparam int TABLE_DEPTH = (HANDLES < (1 << aba_pkg::HANDLE_W)) ?
                                HANDLES : (1 << aba_pkg::HANDLE_W);
   localparam int TAB_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [SPAN_W-1:0] MEMB = SPAN_W'(MEM_BLOCKS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic act_ff, act_in;
   logic [aba_pkg::HANDLE_W-1:0] hnd_ff, hnd_in;
   logic [aba_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [SPAN_W-1:0] lim_ff, lim_in;
   logic [SPAN_W-1:0] step_ff, step_in;
   logic [SPAN_W-1:0] cand_ff, cand_in;
   logic [IDX_W-1:0] rd_start_ff;
   logic [SIZE_W-1:0] rd_size_ff;
   logic [aba_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [aba_pkg::START_W-1:0] res_start_ff, res_start_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [aba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [aba_pkg::START_W-1:0] rsp_start_ff, rsp_start_in;
   logic [aba_pkg::MAP_W-1:0] rsp_map_ff, rsp_map_in;
   logic [MEM_BLOCKS-1:0] free_bits_ff, free_bits_in;
   logic [MEM_BLOCKS-1:0] marks_ff, marks_in;
   logic [TABLE_DEPTH-1:0] handle_valid_ff, handle_valid_in;
   logic [aba_pkg::MSIZE_W-1:0] memory_size_ff;

   logic [IDX_W-1:0]  handle_start [TABLE_DEPTH];
   logic [SIZE_W-1:0] handle_size  [TABLE_DEPTH];

   logic req_fire;
   logic [TAB_W-1:0] hidx;
   logic [TAB_W-1:0] req_idx;
   logic h_in_range;
   logic h_live;
   logic [SPAN_W-1:0] rel_end;
   logic [SPAN_W-1:0] scan_end;
   logic [SPAN_W-1:0] commit_end;
   logic free_at_cand;
   logic mark_hit;
   logic table_we;
   aba_pkg::span_req_type span_req;
   logic [MEM_BLOCKS-1:0] span_mask;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_map_ff, rsp_start_ff, rsp_status_ff};

   assign hidx       = hnd_ff[TAB_W-1:0];
   assign req_idx    = req_tdata[TAB_W-1:0];
   assign h_in_range = (32'(hnd_ff) < HANDLES);
   assign h_live     = h_in_range && handle_valid_ff[hidx];

   assign rel_end    = SPAN_W'(rd_start_ff) + SPAN_W'(rd_size_ff);
   assign scan_end   = cand_ff + SPAN_W'(count_ff);
   assign commit_end = cand_ff + step_ff;
   assign free_at_cand = (cand_ff < MEMB) && free_bits_ff[cand_ff[IDX_W-1:0]];
   assign mark_hit   = |(marks_ff & span_mask);

   // one range unit serves the overlap check, the marking and the release
   always_comb begin
      case (state_ff)
         S_SCAN: begin
            span_req.lo = cand_ff + SPAN_W'(1);
            span_req.hi = scan_end;
         end
         S_COMMIT: begin
            span_req.lo = cand_ff;
            span_req.hi = (commit_end > lim_ff) ? lim_ff : commit_end;
         end
         default: begin
            span_req.lo = SPAN_W'(rd_start_ff);
            span_req.hi = (rel_end > MEMB) ? MEMB : rel_end;
         end
      endcase
   end

   aba_span_unit #(
      .BLOCKS (MEM_BLOCKS)
   ) u_span (
      .req  (span_req),
      .mask (span_mask)
   );

   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      hnd_in          = hnd_ff;
      count_in        = count_ff;
      lim_in          = lim_ff;
      step_in         = step_ff;
      cand_in         = cand_ff;
      res_status_in   = res_status_ff;
      res_start_in    = res_start_ff;
      free_bits_in    = free_bits_ff;
      marks_in        = marks_ff;
      handle_valid_in = handle_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_start_in    = rsp_start_ff;
      rsp_map_in      = rsp_map_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      table_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               act_in   = req_tuser;
               hnd_in   = req_tdata[3:0];
               count_in = req_tdata[10:4];
               lim_in   = (SPAN_W'(memory_size_ff) > MEMB) ? MEMB : SPAN_W'(memory_size_ff);
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_start_in = '0;
            state_in     = S_FINISH;
            if (act_ff) begin
               if (!h_live) begin
                  res_status_in = aba_pkg::ST_ABSENT;
               end else begin
                  free_bits_in          = free_bits_ff | span_mask;
                  marks_in              = marks_ff & ~(MEM_BLOCKS'(1) << rd_start_ff);
                  handle_valid_in[hidx] = 1'b0;
                  res_status_in         = aba_pkg::ST_OK;
                  res_start_in          = aba_pkg::START_W'(rd_start_ff);
               end
            end else if (!h_in_range) begin
               res_status_in = aba_pkg::ST_NOSPACE;
            end else if (h_live) begin
               res_status_in = aba_pkg::ST_USED;
            end else if (count_ff == '0) begin
               res_status_in = aba_pkg::ST_NOSPACE;
            end else begin
               step_in  = aba_pkg::round_pow2(count_ff);
               cand_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cand_ff >= lim_ff) begin
               res_status_in = aba_pkg::ST_NOSPACE;
               res_start_in  = '0;
               state_in      = S_FINISH;
            end else if (free_at_cand && (scan_end <= lim_ff) && !mark_hit) begin
               state_in = S_COMMIT;
            end else begin
               cand_in = cand_ff + step_ff;
            end
         end
         S_COMMIT: begin
            free_bits_in          = free_bits_ff & ~span_mask;
            marks_in              = marks_ff | (MEM_BLOCKS'(1) << cand_ff[IDX_W-1:0]);
            handle_valid_in[hidx] = 1'b1;
            table_we              = 1'b1;
            res_status_in         = aba_pkg::ST_OK;
            res_start_in          = cand_ff[aba_pkg::START_W-1:0];
            state_in              = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_map_in    = aba_pkg::MAP_W'(free_bits_ff);
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         free_bits_ff    <= '1;
         marks_ff        <= '0;
         handle_valid_ff <= '0;
         memory_size_ff  <= aba_pkg::MSIZE_W'(64);
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         free_bits_ff    <= free_bits_in;
         marks_ff        <= marks_in;
         handle_valid_ff <= handle_valid_in;
         if (csr_wen) begin
            memory_size_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      hnd_ff        <= hnd_in;
      count_ff      <= count_in;
      lim_ff        <= lim_in;
      step_ff       <= step_in;
      cand_ff       <= cand_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_map_ff    <= rsp_map_in;
   end

   // handle table: registered read on the request transfer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_start_ff <= handle_start[req_idx];
         rd_size_ff  <= handle_size[req_idx];
      end
      if (table_we) begin
         handle_start[hidx] <= cand_ff[IDX_W-1:0];
         handle_size[hidx]  <= SIZE_W'(span_req.hi - cand_ff);
      end
   end

   `ABA_IMPLIES(a_cand_aligned, clock, reset, state_ff == S_SCAN,
      (cand_ff & (step_ff - SPAN_W'(1))) == '0, "candidate start not aligned to rounded size")
   `ABA_IMPLIES(a_commit_free, clock, reset, state_ff == S_COMMIT, free_at_cand,
      "committing a start block that is not free")
   `ABA_NEXT(a_valid_quiet, clock, reset, (state_ff != S_DECODE) && (state_ff != S_COMMIT),
      $stable(handle_valid_ff), "handle table changed outside decode or commit")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for aligned_block_allocator: directed and random reserve/release
// traffic over several memory sizes, checked against a built-in allocator predictor.
// Depends on aba_pkg and the aligned_block_allocator RTL.

class alloc_scoreboard;
   localparam int BLOCKS  = 64;
   localparam int HANDLES = 16;

   typedef struct packed {
      logic [aba_pkg::STATUS_W-1:0] status;
      logic [aba_pkg::START_W-1:0]  start;
      logic [aba_pkg::MAP_W-1:0]    map;
   } outcome_type;

   logic [BLOCKS-1:0] free_bits;
   logic [BLOCKS-1:0] start_marks;
   bit                live[HANDLES];
   int                base[HANDLES];
   int                span[HANDLES];
   int                mem_size;
   outcome_type       outcome_q[$];
   int                errors;

   function new();
      free_bits   = '1;
      start_marks = '0;
      mem_size    = 64;
      errors      = 0;
      for (int h = 0; h < HANDLES; h++) begin
         live[h] = 0;
         base[h] = 0;
         span[h] = 0;
      end
   endfunction

   function void set_size(logic [aba_pkg::MSIZE_W-1:0] v);
      mem_size = v;
   endfunction

   function int pending();
      return outcome_q.size();
   endfunction

   // random handle in the wanted state, or any handle if none is
   function logic [3:0] pick_handle(bit want_live);
      logic [3:0] pool[$];
      for (int h = 0; h < HANDLES; h++)
         if (live[h] == want_live) pool.push_back(4'(h));
      if (pool.size() == 0) return 4'($urandom_range(HANDLES - 1));
      return pool[$urandom_range(pool.size() - 1)];
   endfunction

   function logic [1:0] reserve_span(int h, int cnt, output int at);
      int  lim, step, i, j, stop;
      bit  fits;
      at = 0;
      if (live[h]) return aba_pkg::ST_USED;
      lim = (mem_size > BLOCKS) ? BLOCKS : mem_size;
      if (cnt == 0) return aba_pkg::ST_NOSPACE;
      step = 1;
      while (step < cnt) step = step * 2;
      for (i = 0; i < lim; i += step) begin
         if (!free_bits[i] || i + cnt - 1 >= lim) continue;
         fits = 1;
         for (j = i + 1; j <= i + cnt - 1; j++)
            if (start_marks[j]) fits = 0;
         if (!fits) continue;
         // mark the rounded span, clipped at the memory end
         stop = (i + step > lim) ? lim : i + step;
         for (j = i; j < stop; j++) free_bits[j] = 1'b0;
         start_marks[i] = 1'b1;
         live[h] = 1;
         base[h] = i;
         span[h] = stop - i;
         at = i;
         return aba_pkg::ST_OK;
      end
      return aba_pkg::ST_NOSPACE;
   endfunction

   function logic [1:0] release_span(int h, output int at);
      int s, e;
      at = 0;
      if (!live[h]) return aba_pkg::ST_ABSENT;
      s = base[h];
      e = s + span[h];
      if (e > BLOCKS) e = BLOCKS;
      for (int j = s; j < e; j++) free_bits[j] = 1'b1;
      start_marks[s] = 1'b0;
      live[h] = 0;
      at = s;
      return aba_pkg::ST_OK;
   endfunction

   function void note_request(logic act, logic [3:0] h, logic [6:0] count);
      outcome_type o;
      int          at;
      if (act == 1'b0) o.status = reserve_span(h, count, at);
      else o.status = release_span(h, at);
      o.start = (o.status == aba_pkg::ST_OK) ? at[5:0] : '0;
      o.map   = free_bits;
      outcome_q.push_back(o);
   endfunction

   function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
   endfunction

   function void check_response(logic [71:0] d);
      outcome_type want;
      if (outcome_q.size() == 0) begin
         flag("unexpected transfer", '0, d[63:0]);
         return;
      end
      want = outcome_q.pop_front();
      if (d[1:0] !== want.status) flag("status", 64'(want.status), 64'(d[1:0]));
      if (d[7:2] !== want.start) flag("start_index", 64'(want.start), 64'(d[7:2]));
      if (d[71:8] !== want.map) flag("free_map", want.map, d[71:8]);
   endfunction
endclass

module testbench;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic              req_tuser;
   // handle[3:0], block_count[10:4], zero[15:11]
   logic [15:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   // status[1:0], start_index[7:2], free_map[71:8]
   logic [71:0]       rsp_tdata;
   logic              csr_wen;
   logic [aba_pkg::MSIZE_W-1:0] csr_wdata;

   alloc_scoreboard   sb = new();
   bit                steady;
   int                stall_left;

   aligned_block_allocator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic logic [6:0] pick_count();
      int r;
      r = $urandom_range(99);
      if (r < 4) return 7'd0;
      if (r < 60) return 7'($urandom_range(4, 1));
      if (r < 85) return 7'($urandom_range(16, 5));
      if (r < 95) return 7'($urandom_range(64, 17));
      return 7'($urandom_range(127, 65));
   endfunction

   // response side: check every transfer and stall at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(3) == 0) stall_left = pick_gap();
      end
   end

   // hold valid across back-to-back transfers; drop it only for a gap
   task automatic send_request(input logic act, input logic [3:0] h, input logic [6:0] count);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {5'b0, count, h};
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, h, count);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_size(input logic [aba_pkg::MSIZE_W-1:0] v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.set_size(v);
   endtask

   task automatic random_traffic(input int n);
      logic [3:0] h;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(99) < 55) begin
            h = ($urandom_range(9) < 7) ? sb.pick_handle(0) : 4'($urandom_range(15));
            send_request(1'b0, h, pick_count());
         end else begin
            h = ($urandom_range(3) != 0) ? sb.pick_handle(1) : 4'($urandom_range(15));
            send_request(1'b1, h, 7'($urandom_range(127)));
         end
      end
   endtask

   initial begin
      int sizes[10];
      req_tvalid <= 1'b0;
      req_tuser  <= 1'b0;
      req_tdata  <= '0;
      csr_wen    <= 1'b0;
      csr_wdata  <= '0;
      reset      <= 1'b1;
      stall_left = 0;
      steady     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_size(7'd64);
      send_request(1'b0, 4'd0, 7'd0);     // zero count
      send_request(1'b0, 4'd0, 7'd1);
      send_request(1'b0, 4'd0, 7'd2);     // handle already live
      send_request(1'b0, 4'd1, 7'd3);     // rounds up to four
      send_request(1'b0, 4'd2, 7'd64);
      send_request(1'b0, 4'd3, 7'd127);   // rounds past memory
      send_request(1'b0, 4'd4, 7'd65);
      send_request(1'b1, 4'd5, 7'd0);     // release of an absent handle
      send_request(1'b1, 4'd1, 7'd127);
      send_request(1'b1, 4'd1, 7'd0);
      send_request(1'b1, 4'd0, 7'd0);
      send_request(1'b0, 4'd15, 7'd64);   // whole memory
      send_request(1'b0, 4'd14, 7'd1);
      send_request(1'b1, 4'd15, 7'd0);
      send_request(1'b0, 4'd7, 7'd5);
      send_request(1'b0, 4'd8, 7'd17);
      send_request(1'b0, 4'd9, 7'd33);
      send_request(1'b0, 4'd10, 7'd1);
      send_request(1'b0, 4'd11, 7'd2);
      send_request(1'b1, 4'd7, 7'd0);
      send_request(1'b1, 4'd8, 7'd0);
      send_request(1'b0, 4'd12, 7'd32);
      drain();

      sizes = '{1, 0, 127, 37, 64, 16, 5, 0, 64, 2};
      sizes[7] = $urandom_range(64, 1);
      for (int p = 0; p < 10; p++) begin
         steady = (p % 3 == 2);
         write_size(7'(sizes[p]));
         random_traffic(123);
         drain();
      end

      steady = 0;
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("aligned_block_allocator regression: pass");
      else
         $display("aligned_block_allocator regression: fail");
      $finish;
   end

   initial begin
      #8000000;
      $display("aligned_block_allocator regression: fail");
      $finish;
   end
endmodule
